/* sv/miller_rabin_single_base_test_unit_macros.svh */
// assertion macros for the miller-rabin test unit checker
// no dependencies; taken in by the checker file with an include
`ifndef MILLER_RABIN_SINGLE_BASE_TEST_UNIT_MACROS_SVH
`define MILLER_RABIN_SINGLE_BASE_TEST_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MRST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MRST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mrst_pkg.sv */
// shared types and constants for the miller-rabin test unit
// used by the channel interfaces, the modular multiplier and the top level
package mrst_pkg;

    localparam int WIDTH  = 32;
    localparam int CAND_W = 32;
    localparam int BASE_W = 32;
    // multiplier operand y walks the wider of the modulus and the base
    localparam int YW     = (WIDTH > BASE_W) ? WIDTH : BASE_W;
    localparam int CNT_W  = $clog2(YW);
    localparam int IDX_W  = $clog2(WIDTH);

    localparam logic [BASE_W-1:0] WITNESS_RESET = BASE_W'(2);
    localparam logic [WIDTH-1:0]  MIN_CANDIDATE = WIDTH'(3);
    localparam logic [WIDTH-1:0]  WORD_ONE      = WIDTH'(1);

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [YW-1:0]    yword_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_REDUCE,
        ST_POW_SQ,
        ST_POW_MUL,
        ST_TEST,
        ST_SQ,
        ST_SQ_CHECK,
        ST_FINISH
    } mrst_state_t;

    typedef struct packed {
        logic   start;
        word_t  x;
        yword_t y;
        word_t  m;
    } mm_cmd_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } mm_rsp_t;

endpackage

/* sv/mrst_if.sv */
// request and result channel interfaces for the miller-rabin test unit
// depends on mrst_pkg for field widths
interface mrst_cand_if
    import mrst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CAND_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface mrst_result_if
    import mrst_pkg::*;
();
    logic valid;
    logic ready;
    logic is_probable_prime;
    logic bad_input;

    modport source (output valid, output is_probable_prime, output bad_input, input ready);
    modport sink   (input valid, input is_probable_prime, input bad_input, output ready);
endinterface

/* sv/mrst_mulmod.sv */
// shared modular multiplier: (x * y) mod m by shift and add, msb of y first
// one modular add per cycle, a doubling and an add phase per bit of y; depends on mrst_pkg
module mrst_mulmod
    import mrst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_cmd_t cmd,
    output mm_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            acc_reg, acc_next;
    word_t            x_reg, x_next;
    word_t            m_reg, m_next;
    yword_t           y_reg, y_next;

    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   red;

    // add_mod(acc, acc) on the doubling phase, add_mod(acc, x) on the add phase
    always_comb
    begin
        sum = {1'b0, acc_reg} + {1'b0, (phase_reg ? x_reg : acc_reg)};
        if (sum >= {1'b0, m_reg})
        begin
            red = sum - {1'b0, m_reg};
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        if (!busy_reg)
        begin
            if (cmd.start)
            begin
                busy_next  = 1'b1;
                phase_next = 1'b0;
                cnt_next   = '0;
                acc_next   = '0;
                x_next     = cmd.x;
                m_next     = cmd.m;
                y_next     = cmd.y;
            end
        end
        else if (!phase_reg)
        begin
            acc_next   = red[WIDTH-1:0];
            phase_next = 1'b1;
        end
        else
        begin
            if (y_reg[YW-1])
            begin
                acc_next = red[WIDTH-1:0];
            end
            y_next     = {y_reg[YW-2:0], 1'b0};
            phase_next = 1'b0;
            if (cnt_reg == CNT_W'(YW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        m_reg   <= m_next;
        y_reg   <= y_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

/* sv/miller_rabin_single_base_test_unit.sv */
// miller-rabin strong probable prime test against one configured witness base
// depends on mrst_pkg, mrst_if (channels) and mrst_mulmod (shared multiplier)
//
//  channel  dir  handshake        payload
//  cand     in   valid / ready    candidate[31:0]
//  result   out  valid / ready    is_probable_prime, bad_input
//  cfg      in   cfg_wr_en        cfg_wr_data[31:0] -> witness base
//
// one request at a time; every modular product goes through the shared
// multiplier. a candidate below three goes straight from idle to the finish
// state. reset sets the base to 2. a result held by a stalled sink keeps the
// next test in its finish state until that result is taken.
module miller_rabin_single_base_test_unit
    import mrst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mrst_cand_if.sink         cand,
    mrst_result_if.source     result,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data
);

    mrst_state_t       state_reg, state_next;
    logic [BASE_W-1:0] base_reg;
    logic              issued_reg, issued_next;
    word_t             n_reg, n_next;
    word_t             d_reg, d_next;
    word_t             b_reg, b_next;
    word_t             a_reg, a_next;
    logic [IDX_W-1:0]  s_reg, s_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic              prime_reg, prime_next;
    logic              bad_reg, bad_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_prime_reg, out_prime_next;
    logic              out_bad_reg, out_bad_next;

    word_t             n_in;
    word_t             top;
    logic              accept;
    logic              out_free;
    logic              exp_bit;
    logic              last_bit;
    logic              hit_one;
    logic              hit_top;
    logic              more_sq;
    logic [IDX_W:0]    r_inc;
    mm_cmd_t           mm_cmd;
    mm_rsp_t           mm_rsp;

    mrst_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mm_cmd),
        .rsp   (mm_rsp)
    );

    assign n_in     = word_t'(cand.candidate);
    assign top      = n_reg - WORD_ONE;
    assign accept   = cand.valid && cand.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign exp_bit  = d_reg[idx_reg];
    assign last_bit = (idx_reg == '0);
    assign hit_one  = (a_reg == WORD_ONE);
    assign hit_top  = (a_reg == top);
    assign r_inc    = {1'b0, r_reg} + (IDX_W + 1)'(1);
    assign more_sq  = r_inc < {1'b0, s_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (n_in < MIN_CANDIDATE) ? ST_FINISH : ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (d_reg[0])
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_SQ:
            begin
                if (mm_rsp.done)
                begin
                    if (exp_bit)
                    begin
                        state_next = ST_POW_MUL;
                    end
                    else if (last_bit)
                    begin
                        state_next = ST_TEST;
                    end
                end
            end
            ST_POW_MUL:
            begin
                if (mm_rsp.done)
                begin
                    state_next = last_bit ? ST_TEST : ST_POW_SQ;
                end
            end
            ST_TEST:
            begin
                if (hit_one || hit_top || s_reg <= IDX_W'(1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_SQ_CHECK:
            begin
                if (hit_one || hit_top || !more_sq)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs: request ready and multiplier command
    always_comb
    begin
        cand.ready   = 1'b0;
        mm_cmd.start = 1'b0;
        mm_cmd.x     = a_reg;
        mm_cmd.y     = yword_t'(a_reg);
        mm_cmd.m     = n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cand.ready = 1'b1;
            end
            ST_REDUCE:
            begin
                // base mod n as 1 * base mod n
                mm_cmd.start = !issued_reg;
                mm_cmd.x     = WORD_ONE;
                mm_cmd.y     = yword_t'(base_reg);
            end
            ST_POW_SQ, ST_SQ:
            begin
                mm_cmd.start = !issued_reg;
            end
            ST_POW_MUL:
            begin
                mm_cmd.start = !issued_reg;
                mm_cmd.y     = yword_t'(b_reg);
            end
            ST_SPLIT, ST_TEST, ST_SQ_CHECK, ST_FINISH:
            begin
                mm_cmd.start = 1'b0;
            end
            default:
            begin
                cand.ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        issued_next    = issued_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        b_next         = b_reg;
        a_next         = a_reg;
        s_next         = s_reg;
        idx_next       = idx_reg;
        r_next         = r_reg;
        prime_next     = prime_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        out_bad_next   = out_bad_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (mm_cmd.start)
        begin
            issued_next = 1'b1;
        end
        if (mm_rsp.done)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                n_next     = n_in;
                d_next     = n_in - WORD_ONE;
                s_next     = '0;
                prime_next = 1'b0;
                bad_next   = (n_in < MIN_CANDIDATE);
            end
            ST_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[WIDTH-1:1]};
                    s_next = s_reg + IDX_W'(1);
                end
            end
            ST_REDUCE:
            begin
                if (mm_rsp.done)
                begin
                    b_next   = mm_rsp.result;
                    a_next   = WORD_ONE;
                    idx_next = IDX_W'(WIDTH - 1);
                end
            end
            ST_POW_SQ:
            begin
                if (mm_rsp.done)
                begin
                    a_next = mm_rsp.result;
                    if (!exp_bit && !last_bit)
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            ST_POW_MUL:
            begin
                if (mm_rsp.done)
                begin
                    a_next = mm_rsp.result;
                    if (!last_bit)
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            ST_TEST:
            begin
                prime_next = hit_one || hit_top;
                r_next     = IDX_W'(1);
            end
            ST_SQ:
            begin
                if (mm_rsp.done)
                begin
                    a_next = mm_rsp.result;
                end
            end
            ST_SQ_CHECK:
            begin
                // reaching 1 is composite, reaching n-1 is prime
                prime_next = !hit_one && hit_top;
                r_next     = r_inc[IDX_W-1:0];
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                    out_bad_next   = bad_reg;
                end
            end
            default:
            begin
                issued_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= WITNESS_RESET;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        b_reg         <= b_next;
        a_reg         <= a_next;
        s_reg         <= s_next;
        idx_reg       <= idx_next;
        r_reg         <= r_next;
        prime_reg     <= prime_next;
        bad_reg       <= bad_next;
        out_prime_reg <= out_prime_next;
        out_bad_reg   <= out_bad_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.is_probable_prime = out_prime_reg;
    assign result.bad_input         = out_bad_reg;

endmodule

/* sv/mrst_checker.sv */
// port-level checker for the miller-rabin test unit, bound to the top level
// depends on the assertion macros header and the top-level port names
`include "miller_rabin_single_base_test_unit_macros.svh"

module mrst_checker
(
    input logic clk,
    input logic rst_n,
    input logic cand_valid,
    input logic cand_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_prime,
    input logic res_bad
);

    // the unit is not ready in the cycle after it accepts a request
    `MRST_ASSERT_NEXT(a_busy_after_request, clk, rst_n, cand_valid && cand_ready, !cand_ready, "request accepted but unit still ready")

    // a rejected candidate is never reported prime
    `MRST_ASSERT_NOW(a_bad_not_prime, clk, rst_n, res_valid && res_bad, !res_prime, "bad input reported as prime")

    // a new result shows up together with the unit going idle
    `MRST_ASSERT_NOW(a_result_then_idle, clk, rst_n, $rose(res_valid), cand_ready, "result raised while unit busy")

    // stalled result holds
    `MRST_ASSERT_NEXT(a_result_holds, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_prime) && $stable(res_bad), "stalled result changed")

endmodule

bind miller_rabin_single_base_test_unit mrst_checker u_mrst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (cand.valid),
    .cand_ready (cand.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_prime  (result.is_probable_prime),
    .res_bad    (result.bad_input)
);
